### hw/rtl/jsu_pkg.sv
// Shared types, codes and helper functions for the JSON string unescaper.
package jsu_pkg;

	// Decoder phase
	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_STR  = 2'd1,
		PH_ESC  = 2'd2,
		PH_HEX  = 2'd3
	} jsu_phase_t;

	// Result status codes
	localparam logic [1:0] ST_BYTE = 2'd0;
	localparam logic [1:0] ST_DONE = 2'd1;
	localparam logic [1:0] ST_ERR  = 2'd2;

	// Characters of interest
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	// Output queue geometry
	localparam int unsigned OutDepth = 8;
	localparam int unsigned OutPtrW  = $clog2(OutDepth);
	localparam int unsigned OutCntW  = $clog2(OutDepth + 1);
	localparam int unsigned MaxRes   = 3;

	// One result
	typedef struct packed {
		logic [7:0] data;
		logic [1:0] status;
		logic       last;
	} jsu_item_t;

	// All results of one request
	typedef struct packed {
		logic [1:0]            count;
		jsu_item_t [MaxRes-1:0] item;
	} jsu_res_t;

	// Hex digit: {valid, value}
	function automatic logic [4:0] hex_nib(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end
		return r;
	endfunction

	// Whitespace skipped while idle
	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

endpackage

### hw/rtl/jsu_decode.sv
// Decoder: phase and \u accumulator registers plus the per-request decode logic.
module jsu_decode import jsu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  logic [7:0] in_byte_s1,
	input  logic       eoi_s1,
	output jsu_res_t   res
);

	jsu_phase_t  phase_q, phase_d;
	logic [1:0]  digits_q, digits_d;
	logic [11:0] acc_q, acc_d;
	logic [4:0]  nib;
	logic [15:0] cp;
	logic [7:0]  esc_val;
	logic        esc_ok;

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			digits_q <= 2'd0;
			acc_q    <= 12'd0;
		end else if (fire) begin
			phase_q  <= phase_d;
			digits_q <= digits_d;
			acc_q    <= acc_d;
		end
	end

	assign nib = hex_nib(in_byte_s1);
	assign cp  = {acc_q, nib[3:0]};

	// Simple escape letters
	always_comb begin
		esc_ok  = 1'b1;
		esc_val = 8'h00;
		unique case (in_byte_s1)
			CH_QUOTE:  esc_val = CH_QUOTE;
			CH_BSLASH: esc_val = CH_BSLASH;
			CH_SLASH:  esc_val = CH_SLASH;
			8'h62:     esc_val = 8'h08;
			8'h66:     esc_val = 8'h0C;
			8'h6E:     esc_val = 8'h0A;
			8'h72:     esc_val = 8'h0D;
			8'h74:     esc_val = 8'h09;
			default:   esc_ok  = 1'b0;
		endcase
	end

	// Next state and results
	always_comb begin
		logic err;
		err      = 1'b0;
		phase_d  = phase_q;
		digits_d = digits_q;
		acc_d    = acc_q;
		res      = '0;
		unique case (phase_q)
			PH_IDLE: begin
				if (!eoi_s1 && !is_ws(in_byte_s1)) begin
					if (in_byte_s1 == CH_QUOTE) phase_d = PH_STR;
					else err = 1'b1;
				end
			end
			PH_STR: begin
				if (eoi_s1 || in_byte_s1 < CH_SPACE) begin
					err = 1'b1;
				end else if (in_byte_s1 == CH_QUOTE) begin
					phase_d = PH_IDLE;
					res.count = 2'd1;
					res.item[0] = '{data: 8'h00, status: ST_DONE, last: 1'b1};
				end else if (in_byte_s1 == CH_BSLASH) begin
					phase_d = PH_ESC;
				end else begin
					res.count = 2'd1;
					res.item[0] = '{data: in_byte_s1, status: ST_BYTE, last: 1'b1};
				end
			end
			PH_ESC: begin
				if (eoi_s1) begin
					err = 1'b1;
				end else if (in_byte_s1 == 8'h75) begin
					phase_d  = PH_HEX;
					digits_d = 2'd0;
					acc_d    = 12'd0;
				end else if (esc_ok) begin
					phase_d = PH_STR;
					res.count = 2'd1;
					res.item[0] = '{data: esc_val, status: ST_BYTE, last: 1'b1};
				end else begin
					err = 1'b1;
				end
			end
			PH_HEX: begin
				if (eoi_s1 || !nib[4]) begin
					err = 1'b1;
				end else if (digits_q != 2'd3) begin
					acc_d    = {acc_q[7:0], nib[3:0]};
					digits_d = digits_q + 2'd1;
				end else begin
					phase_d  = PH_STR;
					digits_d = 2'd0;
					acc_d    = 12'd0;
					// UTF-8 encode of the code point
					if (cp[15:7] == 9'd0) begin
						res.count = 2'd1;
						res.item[0] = '{data: {1'b0, cp[6:0]}, status: ST_BYTE, last: 1'b1};
					end else if (cp[15:11] == 5'd0) begin
						res.count = 2'd2;
						res.item[0] = '{data: {3'b110, cp[10:6]}, status: ST_BYTE,
							last: 1'b0};
						res.item[1] = '{data: {2'b10, cp[5:0]}, status: ST_BYTE, last: 1'b1};
					end else begin
						res.count = 2'd3;
						res.item[0] = '{data: {4'b1110, cp[15:12]}, status: ST_BYTE,
							last: 1'b0};
						res.item[1] = '{data: {2'b10, cp[11:6]}, status: ST_BYTE,
							last: 1'b0};
						res.item[2] = '{data: {2'b10, cp[5:0]}, status: ST_BYTE, last: 1'b1};
					end
				end
			end
			default: err = 1'b1;
		endcase
		// Any malformed input ends the string
		if (err) begin
			phase_d  = PH_IDLE;
			digits_d = 2'd0;
			acc_d    = 12'd0;
			res      = '0;
			res.count = 2'd1;
			res.item[0] = '{data: 8'h00, status: ST_ERR, last: 1'b1};
		end
	end

endmodule

### hw/rtl/jsu_out_fifo.sv
// Output queue: takes up to three results per cycle, hands out one per cycle unless out_stall holds it.
module jsu_out_fifo import jsu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  jsu_res_t   res,
	output logic       room,
	output logic       out_valid,
	input  logic       out_stall,
	output jsu_item_t  out_item
);

	jsu_item_t            mem_q [OutDepth];
	logic [OutPtrW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [OutCntW-1:0]   cnt_q;
	logic [1:0]           n_push;
	logic                 pop;

	assign n_push    = push ? res.count : 2'd0;
	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && !out_stall;
	assign out_item  = mem_q[rd_ptr_q];
	// Room for a full request of results
	assign room      = (cnt_q <= OutCntW'(OutDepth - MaxRes));

	// Storage
	always_ff @(posedge clk) begin
		for (int k = 0; k < MaxRes; k++) begin
			if (2'(k) < n_push) mem_q[wr_ptr_q + OutPtrW'(k)] <= res.item[k];
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + OutPtrW'(n_push);
			if (pop) rd_ptr_q <= rd_ptr_q + OutPtrW'(1);
			cnt_q <= cnt_q + OutCntW'(n_push) - OutCntW'(pop);
		end
	end

endmodule

### hw/rtl/json_string_unescaper.sv
// JSON string unescaper top level: input register, decoder and output queue.
//
// Takes one text byte per cycle unless stalled and decodes quoted JSON strings
// into content bytes (escapes resolved, \uXXXX written as UTF-8), then a done or
// an error result. A request is registered and decoded; its one to three results
// go into an eight-entry queue that drains one result per unstalled cycle.
// Sustained rate is one request per cycle while each request gives at most one
// result and output is not stalled; the single output port sets the limit, so a
// \u escape that yields three bytes needs three outputs, spread over its six
// input bytes. Input stalls only when the queue lacks room for three results.
module json_string_unescaper import jsu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       end_of_input,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic [1:0] status,
	output logic       last
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eoi_s1;
	logic       room;
	logic       fire;
	jsu_res_t   res;
	jsu_item_t  item;

	assign fire     = valid_s1 && room;
	assign in_stall = valid_s1 && !room;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= in_byte;
			eoi_s1  <= end_of_input;
		end
	end

	jsu_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.in_byte_s1 (byte_s1),
		.eoi_s1     (eoi_s1),
		.res        (res)
	);

	jsu_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fire),
		.res       (res),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (item)
	);

	assign out_byte = item.data;
	assign status   = item.status;
	assign last     = item.last;

endmodule

### bench/tb_json_string_unescaper.sv
// Self-checking testbench for the streaming JSON string unescaper.
module tb_json_string_unescaper;
	timeunit 1ns;
	timeprecision 1ps;

	import jsu_pkg::*;

	// Run control
	localparam int unsigned LIMIT_CYCLES = 400000;
	localparam int unsigned HOLD_CYCLES  = 200;
	localparam int unsigned DRAIN_CYCLES = 20;
	localparam int unsigned RANDOM_REQS  = 250;
	localparam int unsigned MAX_WAIT     = 18;
	localparam int unsigned MAX_REPORTS  = 10;

	// Characters used by the stimulus and the decoder model
	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_US  = 8'h1F;
	localparam logic [7:0] CH_DEL = 8'h7F;
	localparam logic [7:0] CH_TOP = 8'hFF;
	localparam logic [7:0] LT_0   = 8'h30;
	localparam logic [7:0] LT_UA  = 8'h41;
	localparam logic [7:0] LT_LA  = 8'h61;
	localparam logic [7:0] LT_B   = 8'h62;
	localparam logic [7:0] LT_F   = 8'h66;
	localparam logic [7:0] LT_N   = 8'h6E;
	localparam logic [7:0] LT_Q   = 8'h71;
	localparam logic [7:0] LT_R   = 8'h72;
	localparam logic [7:0] LT_T   = 8'h74;
	localparam logic [7:0] LT_U   = 8'h75;

	// Values written for the control escapes
	localparam logic [7:0] VAL_BS = 8'h08;
	localparam logic [7:0] VAL_LF = 8'h0A;
	localparam logic [7:0] VAL_FF = 8'h0C;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] in_byte;
	logic       end_of_input;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] out_byte;
	logic [1:0] status;
	logic       last;

	// Decoder model state
	jsu_phase_t  dec_phase = PH_IDLE;
	logic [1:0]  hex_cnt   = '0;
	logic [11:0] cp_acc    = '0;

	// Results still owed by the block, oldest first
	jsu_item_t decoded_q [$];

	int unsigned n_errors   = 0;
	int unsigned n_reported = 0;
	int unsigned cycle_cnt  = 0;
	int unsigned text_reqs  = 0;
	bit          tx_idle_on = 1'b1;
	bit          rx_idle_on = 1'b1;
	bit          hold_req   = 1'b0;
	bit          hold_rx    = 1'b0;

	json_string_unescaper DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_byte     (in_byte),
		.end_of_input(end_of_input),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.status      (status),
		.last        (last)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog
	initial begin : watchdog
		forever begin
			@(posedge clk);
			cycle_cnt++;
			if (cycle_cnt > LIMIT_CYCLES) begin
				$display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
					decoded_q.size());
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------- model

	function automatic bit is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic int hex_val(input logic [7:0] c);
		if (c >= LT_0 && c <= LT_0 + 8'd9) return int'(c - LT_0);
		if (c >= LT_UA && c <= LT_UA + 8'd5) return int'(c - LT_UA) + 10;
		if (c >= LT_LA && c <= LT_LA + 8'd5) return int'(c - LT_LA) + 10;
		return -1;
	endfunction

	// Single-letter escapes; returns 0 for anything else (\u included)
	function automatic bit escape_value(input logic [7:0] c, output logic [7:0] v);
		v = c;
		case (c)
			CH_QUOTE, CH_BSLASH, CH_SLASH: return 1'b1;
			LT_B: v = VAL_BS;
			LT_F: v = VAL_FF;
			LT_N: v = VAL_LF;
			LT_R: v = CH_CR;
			LT_T: v = CH_TAB;
			default: return 1'b0;
		endcase
		return 1'b1;
	endfunction

	function automatic void push_result(input logic [7:0] d, input logic [1:0] st,
			input logic lst);
		jsu_item_t r;
		r.data   = d;
		r.status = st;
		r.last   = lst;
		decoded_q = {decoded_q, r};
	endfunction

	function automatic void push_error();
		dec_phase = PH_IDLE;
		hex_cnt   = '0;
		cp_acc    = '0;
		push_result(8'h00, ST_ERR, 1'b1);
	endfunction

	// UTF-8 encoding of one BMP code point, surrogates unpaired
	function automatic void push_utf8(input logic [15:0] cp);
		if (cp <= 16'h007F) begin
			push_result(cp[7:0], ST_BYTE, 1'b1);
		end else if (cp <= 16'h07FF) begin
			push_result({3'b110, cp[10:6]}, ST_BYTE, 1'b0);
			push_result({2'b10, cp[5:0]}, ST_BYTE, 1'b1);
		end else begin
			push_result({4'b1110, cp[15:12]}, ST_BYTE, 1'b0);
			push_result({2'b10, cp[11:6]}, ST_BYTE, 1'b0);
			push_result({2'b10, cp[5:0]}, ST_BYTE, 1'b1);
		end
	endfunction

	// Advance the model by one request; returns 0 when the request is skipped idle input
	function automatic bit decode_byte(input logic [7:0] c, input logic eoi);
		int          d;
		logic [7:0]  esc;
		logic [15:0] cp;
		if (dec_phase == PH_IDLE) begin
			if (eoi || is_space(c)) return 1'b0;
			if (c == CH_QUOTE) dec_phase = PH_STR;
			else push_error();
			return 1'b1;
		end
		if (eoi) begin
			push_error();
			return 1'b1;
		end
		case (dec_phase)
			PH_STR: begin
				if (c == CH_QUOTE) begin
					dec_phase = PH_IDLE;
					push_result(8'h00, ST_DONE, 1'b1);
				end else if (c < CH_SPACE) begin
					push_error();
				end else if (c == CH_BSLASH) begin
					dec_phase = PH_ESC;
				end else begin
					push_result(c, ST_BYTE, 1'b1);
				end
			end
			PH_ESC: begin
				if (c == LT_U) begin
					dec_phase = PH_HEX;
					hex_cnt   = '0;
					cp_acc    = '0;
				end else if (escape_value(c, esc)) begin
					dec_phase = PH_STR;
					push_result(esc, ST_BYTE, 1'b1);
				end else begin
					push_error();
				end
			end
			default: begin
				d = hex_val(c);
				if (d < 0) begin
					push_error();
				end else if (hex_cnt < 2'd3) begin
					cp_acc  = {cp_acc[7:0], 4'(d)};
					hex_cnt = hex_cnt + 2'd1;
				end else begin
					cp        = {cp_acc, 4'(d)};
					dec_phase = PH_STR;
					hex_cnt   = '0;
					cp_acc    = '0;
					push_utf8(cp);
				end
			end
		endcase
		return 1'b1;
	endfunction

	// ------------------------------------------------------------- stimulus

	// Offer one request after a random gap and hold it until accepted
	task automatic send_req(input logic [7:0] b, input logic eoi);
		int unsigned gap;
		gap = tx_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		in_byte      <= b;
		end_of_input <= eoi;
		@(posedge clk);
		while (in_stall !== 1'b0) @(posedge clk);
		if (decode_byte(b, eoi)) text_reqs++;
	endtask

	// Stop offering and wait until every owed result has come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (decoded_q.size() != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] ws_byte();
		int unsigned k;
		k = $urandom_range(0, 5);
		return (k == 5) ? CH_SPACE : CH_TAB + 8'(k);
	endfunction

	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(CH_SPACE, CH_TOP));
		while (b == CH_QUOTE || b == CH_BSLASH);
		return b;
	endfunction

	function automatic logic [7:0] esc_letter();
		case ($urandom_range(0, 7))
			0: return CH_QUOTE;
			1: return CH_BSLASH;
			2: return CH_SLASH;
			3: return LT_B;
			4: return LT_F;
			5: return LT_N;
			6: return LT_R;
			default: return LT_T;
		endcase
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		if (v < 4'd10) return LT_0 + 8'(v);
		return ($urandom_range(0, 1) ? LT_UA : LT_LA) + 8'(v - 4'd10);
	endfunction

	function automatic logic [7:0] non_hex_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255));
		while (hex_val(b) >= 0);
		return b;
	endfunction

	// Code points spread over the one, two and three byte encodings
	function automatic logic [15:0] draw_code_point();
		case ($urandom_range(0, 5))
			0: return 16'($urandom_range(16'h0000, 16'h007F));
			1: return 16'($urandom_range(16'h0080, 16'h07FF));
			2: return 16'($urandom_range(16'h0800, 16'hFFFF));
			3: begin
				case ($urandom_range(0, 5))
					0: return 16'h0000;
					1: return 16'h007F;
					2: return 16'h0080;
					3: return 16'h07FF;
					4: return 16'h0800;
					default: return 16'hFFFF;
				endcase
			end
			4: return 16'($urandom_range(16'hD800, 16'hDFFF));
			default: return 16'($urandom_range(0, 16'hFFFF));
		endcase
	endfunction

	task automatic send_unicode(input logic [15:0] cp);
		send_req(CH_BSLASH, 1'b0);
		send_req(LT_U, 1'b0);
		for (int i = 3; i >= 0; i--) send_req(hex_char(cp[i*4 +: 4]), 1'b0);
	endtask

	// One quoted string with random content; most close cleanly, some break
	task automatic send_string();
		int unsigned kind;
		logic [7:0]  b;
		logic [7:0]  tmp;
		repeat ($urandom_range(0, 2)) send_req(ws_byte(), 1'b0);
		send_req(CH_QUOTE, 1'b0);
		repeat ($urandom_range(0, 8)) begin
			kind = $urandom_range(0, 19);
			if (kind < 11) begin
				send_req(plain_byte(), 1'b0);
			end else if (kind < 16) begin
				send_req(CH_BSLASH, 1'b0);
				send_req(esc_letter(), 1'b0);
			end else begin
				send_unicode(draw_code_point());
			end
		end
		kind = $urandom_range(0, 19);
		case (kind)
			15: send_req(8'($urandom_range(0, 255)), 1'b1);
			16: send_req(8'($urandom_range(CH_NUL, CH_US)), 1'b0);
			17: begin
				do b = 8'($urandom_range(0, 255));
				while (escape_value(b, tmp) || b == LT_U);
				send_req(CH_BSLASH, 1'b0);
				send_req(b, 1'b0);
			end
			18: begin
				send_req(CH_BSLASH, 1'b0);
				send_req(LT_U, 1'b0);
				repeat ($urandom_range(0, 3))
					send_req(hex_char(4'($urandom_range(0, 15))), 1'b0);
				send_req(non_hex_byte(), 1'b0);
			end
			19: begin
				send_req(CH_BSLASH, 1'b0);
				send_req(8'($urandom_range(0, 255)), 1'b1);
			end
			default: send_req(CH_QUOTE, 1'b0);
		endcase
	endtask

	// ---------------------------------------------------------------- tests

	// Idle: whitespace and end of input are skipped, other bytes fail
	task automatic test_idle_skip();
		send_req(CH_SPACE, 1'b0);
		send_req(CH_CR, 1'b0);
		send_req(CH_TOP, 1'b1);
		send_req(CH_NUL, 1'b0);
	endtask

	// Literal bytes, high bytes pass through, control byte fails
	task automatic test_string_body();
		send_req(CH_QUOTE, 1'b0);
		send_req(CH_TOP, 1'b0);
		send_req(CH_DEL, 1'b0);
		send_req(CH_US, 1'b0);
	endtask

	// Escapes: single letter, \u0000, three-byte \uFFFF, unknown letter
	task automatic test_escapes();
		send_req(CH_QUOTE, 1'b0);
		send_req(CH_BSLASH, 1'b0);
		send_req(LT_T, 1'b0);
		send_unicode(16'h0000);
		send_unicode(16'hFFFF);
		send_req(CH_BSLASH, 1'b0);
		send_req(LT_Q, 1'b0);
	endtask

	// Text ends inside an open string
	task automatic test_unterminated();
		send_req(CH_QUOTE, 1'b0);
		send_req(CH_NUL, 1'b1);
		wait_drained();
	endtask

	// Receiver holds off while the sender streams three-byte escapes at full rate
	task automatic test_backpressure();
		tx_idle_on = 1'b0;
		hold_req   = 1'b1;
		send_req(CH_QUOTE, 1'b0);
		repeat (12) send_unicode(16'($urandom_range(16'h0800, 16'hFFFF)));
		repeat (10) send_req(plain_byte(), 1'b0);
		send_req(CH_QUOTE, 1'b0);
		wait_drained();
		tx_idle_on = 1'b1;
	endtask

	// Mostly well-formed strings, with idle noise and drain pauses mixed in
	task automatic test_random_text();
		int unsigned k;
		text_reqs = 0;
		while (text_reqs < RANDOM_REQS) begin
			if ($urandom_range(0, 7) == 0) tx_idle_on = ~tx_idle_on;
			if ($urandom_range(0, 7) == 0) rx_idle_on = ~rx_idle_on;
			k = $urandom_range(0, 11);
			if (k == 0) send_req(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
			else if (k == 1) wait_drained();
			else send_string();
		end
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	// ------------------------------------------------------------- checking

	task automatic report(input string msg);
		n_errors++;
		if (n_reported < MAX_REPORTS) $display("%0t: %s", $realtime, msg);
		n_reported++;
	endtask

	// Long receiver hold-off, timed here so the receiver only watches the flag
	initial begin : rx_holdoff
		forever begin
			wait (hold_req);
			hold_rx = 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_rx  = 1'b0;
			hold_req = 1'b0;
		end
	end

	// Receiver: random stalls, compare each accepted result with the oldest owed one
	initial begin : rx_side
		int unsigned wait_n;
		jsu_item_t   want;
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			wait_n = rx_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
			// A hold-off always asserts out_stall
			if (hold_rx && wait_n == 0) wait_n = 1;
			if (wait_n > 0) begin
				out_stall <= 1'b1;
				repeat (wait_n) @(posedge clk);
				while (hold_rx) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (out_valid !== 1'b1) @(posedge clk);
			if (decoded_q.size() == 0) begin
				report($sformatf("unexpected result data=%02h status=%0d last=%0b",
					out_byte, status, last));
			end else begin
				want = decoded_q.pop_front();
				if (out_byte !== want.data || status !== want.status || last !== want.last)
					report($sformatf({"expected data=%02h status=%0d last=%0b, ",
						"got data=%02h status=%0d last=%0b"},
						want.data, want.status, want.last, out_byte, status, last));
			end
		end
	end

	// Main sequence
	initial begin : main_seq
		arst_n       <= 1'b0;
		in_valid     <= 1'b0;
		in_byte      <= 8'h00;
		end_of_input <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		test_idle_skip();
		test_string_body();
		test_escapes();
		test_unterminated();
		test_backpressure();
		test_random_text();

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_errors == 0 && decoded_q.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

### sim.f
hw/rtl/jsu_pkg.sv
hw/rtl/jsu_decode.sv
hw/rtl/jsu_out_fifo.sv
hw/rtl/json_string_unescaper.sv
bench/tb_json_string_unescaper.sv
